// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros shared by the parser modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge out of reset
`define IAP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("parser assertion failed");

// condition must never be seen out of reset
`define IAP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("parser forbidden condition seen");

`else

`define IAP_ASSERT(label, clk, rst_n, prop)
`define IAP_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/iap_pkg.sv -----
// ----------------------------------------------------------------------------
// iap_pkg
// types and constants of the angle frame parser
// ----------------------------------------------------------------------------
package iap_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_DEFAULT  = 8'h53;
  localparam logic [3:0] POS_TYPE      = 4'd1;
  localparam logic [3:0] POS_FIRST_PAY = 4'd2;
  localparam logic [3:0] POS_LAST_PAY  = 4'd7;
  localparam logic [3:0] SUM_LEN       = 4'd10;
  localparam int unsigned PAY_BYTES    = 6;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        ok;
  } result_t;

endpackage

// ----- design/iap_frame.sv -----
// ----------------------------------------------------------------------------
// iap_frame
// frame tracking state, running sum, payload store and held angle words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iap_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       type_code_i,
  output logic             frame_end_o,
  output logic             res_fire_o,
  output iap_pkg::result_t res_o
);
  import iap_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] roll_r, roll_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [15:0] yaw_r, yaw_nxt;
  logic [7:0]  payload_r [PAY_BYTES];
  logic        pay_we;
  logic [2:0]  pay_idx;
  logic        sum_ok;
  logic [15:0] roll_new, pitch_new, yaw_new;

  assign roll_new  = {payload_r[1], payload_r[0]};
  assign pitch_new = {payload_r[3], payload_r[2]};
  assign yaw_new   = {payload_r[5], payload_r[4]};
  assign sum_ok    = (byte_i == sum_r);
  assign pay_idx   = 3'(count_r - POS_FIRST_PAY);

  assign frame_end_o = (phase_r == PH_COLLECT) && (count_r >= SUM_LEN);
  assign res_fire_o  = step_i && frame_end_o;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    pay_we    = 1'b0;
    unique case (phase_r)
      PH_TYPE: begin
        // stays here on a mismatch, even for another header byte
        if (byte_i == type_code_i) begin
          sum_nxt   = sum_r + byte_i;
          phase_nxt = PH_COLLECT;
          count_nxt = POS_FIRST_PAY;
        end
      end
      PH_COLLECT: begin
        if (count_r < SUM_LEN) begin
          pay_we    = (count_r >= POS_FIRST_PAY) && (count_r <= POS_LAST_PAY);
          sum_nxt   = sum_r + byte_i;
          count_nxt = count_r + 4'd1;
        end else begin
          if (sum_ok) begin
            roll_nxt  = roll_new;
            pitch_nxt = pitch_new;
            yaw_nxt   = yaw_new;
          end
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          sum_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (byte_i == HEADER_BYTE) begin
          sum_nxt   = HEADER_BYTE;
          count_nxt = POS_TYPE;
          phase_nxt = PH_TYPE;
        end
      end
    endcase
  end

  always_comb begin
    res_o.roll  = roll_nxt;
    res_o.pitch = pitch_nxt;
    res_o.yaw   = yaw_nxt;
    res_o.ok    = sum_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      sum_r   <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && pay_we) begin
      payload_r[pay_idx] <= byte_i;
    end
  end

  `IAP_ASSERT(a_count_range, clk, rst_n, (phase_r != PH_COLLECT) || ((count_r >= POS_FIRST_PAY) && (count_r <= SUM_LEN)))
  `IAP_ASSERT(a_back_to_hunt, clk, rst_n, res_fire_o |=> (phase_r == PH_HUNT) && (sum_r == 8'd0))
  `IAP_ASSERT(a_bad_sum_holds, clk, rst_n, (res_fire_o && !sum_ok) |=> $stable(roll_r) && $stable(pitch_r) && $stable(yaw_r))

endmodule

// ----- design/iap_out_reg.sv -----
// ----------------------------------------------------------------------------
// iap_out_reg
// result register on the output channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iap_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  iap_pkg::result_t data_i,
  output logic             free_o,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      out_roll_raw,
  output logic [15:0]      out_pitch_raw,
  output logic [15:0]      out_yaw_raw,
  output logic             out_checksum_ok
);
  import iap_pkg::*;

  logic    vld_r;
  result_t data_r;
  logic    taken;

  assign taken  = vld_r && !out_stall;
  assign free_o = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load_i) begin
      vld_r <= 1'b1;
    end else if (taken) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= data_i;
    end
  end

  assign out_valid       = vld_r;
  assign out_roll_raw    = data_r.roll;
  assign out_pitch_raw   = data_r.pitch;
  assign out_yaw_raw     = data_r.yaw;
  assign out_checksum_ok = data_r.ok;

  `IAP_NEVER(a_no_overwrite, clk, rst_n, load_i && vld_r && out_stall)
  `IAP_ASSERT(a_load_shows, clk, rst_n, load_i |=> vld_r)
  `IAP_ASSERT(a_taken_empties, clk, rst_n, (taken && !load_i) |=> !vld_r)

endmodule

// ----- design/imu_angle_packet_parser.sv -----
// ----------------------------------------------------------------------------
// imu_angle_packet_parser: 11-byte angle frame parser with sum checksum
// a frame's last word reaches out_valid via the input and result registers
// throughput: one byte word per cycle; in_stall only while a result is stuck
// reset (rst_n low, synchronous): parser hunts for a header, held angles zero
// ----------------------------------------------------------------------------
module imu_angle_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // byte words from the serial receiver
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // one result word per completed frame
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_roll_raw,
  output logic [15:0] out_pitch_raw,
  output logic [15:0] out_yaw_raw,
  output logic        out_checksum_ok,
  // frame type register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_frame_type_code
);
  import iap_pkg::*;

  // input register stage
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_take;

  // frame type register
  logic [7:0] type_code_r;

  // hand-off between stages
  logic    frame_end;
  logic    res_fire;
  result_t res;
  logic    out_free;
  logic    step;

  // always writable; user must write only while parser is idle; not enforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r <= TYPE_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      type_code_r <= cfg_frame_type_code;
    end
  end

  // a held word moves on unless it closes a frame and the result register
  // is full and stalled
  assign step     = in_vld_r && (!frame_end || out_free);
  assign in_stall = in_vld_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // header hunt, type match, payload capture and checksum compare
  iap_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .byte_i      (in_byte_r),
    .type_code_i (type_code_r),
    .frame_end_o (frame_end),
    .res_fire_o  (res_fire),
    .res_o       (res)
  );

  // result register, free again as soon as the consumer takes it
  iap_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_i          (res_fire),
    .data_i          (res),
    .free_o          (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_roll_raw    (out_roll_raw),
    .out_pitch_raw   (out_pitch_raw),
    .out_yaw_raw     (out_yaw_raw),
    .out_checksum_ok (out_checksum_ok)
  );

endmodule
